>>> hdl/scta_pkg.sv
// Package for the scan code decoder: event codes, modifier bits and the key map.
`default_nettype none

package scta_pkg;

    // Event kinds on the result channel
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_CHAR      = 3'd1;
    localparam logic [2:0] EV_EOF       = 3'd2;
    localparam logic [2:0] EV_INTERRUPT = 3'd3;
    localparam logic [2:0] EV_STOP      = 3'd4;

    // Modifier bit masks
    localparam logic [3:0] MOD_SHIFT = 4'b0001;
    localparam logic [3:0] MOD_CTRL  = 4'b0010;
    localparam logic [3:0] MOD_ALT   = 4'b0100;
    localparam logic [3:0] MOD_META  = 4'b1000;
    localparam int unsigned MOD_CTRL_BIT = 1;

    // Control characters matched while ctrl is held
    localparam logic [6:0] CH_C = 7'h63;
    localparam logic [6:0] CH_D = 7'h64;
    localparam logic [6:0] CH_Z = 7'h7a;

    // Scan code fields
    localparam int unsigned BREAK_BIT = 7;

    typedef struct packed {
        logic       is_mod;
        logic [3:0] mod_mask;
        logic [6:0] ch;
    } key_entry_t;

    // Look up one key: character from the plain or shifted half, or a modifier mask
    function automatic key_entry_t key_lookup(input logic shift, input logic [6:0] idx);
        logic [13:0] pair;
        key_entry_t  e;
        pair = 14'h0;
        e    = '0;
        case (idx)
            7'd1:  pair = {7'h1b, 7'h1b};
            7'd2:  pair = {7'h31, 7'h21};
            7'd3:  pair = {7'h32, 7'h40};
            7'd4:  pair = {7'h33, 7'h23};
            7'd5:  pair = {7'h34, 7'h24};
            7'd6:  pair = {7'h35, 7'h25};
            7'd7:  pair = {7'h36, 7'h5e};
            7'd8:  pair = {7'h37, 7'h26};
            7'd9:  pair = {7'h38, 7'h2a};
            7'd10: pair = {7'h39, 7'h28};
            7'd11: pair = {7'h30, 7'h29};
            7'd12: pair = {7'h2d, 7'h5f};
            7'd13: pair = {7'h3d, 7'h2b};
            7'd14: pair = {7'h08, 7'h08};
            7'd15: pair = {7'h09, 7'h09};
            7'd16: pair = {7'h71, 7'h51};
            7'd17: pair = {7'h77, 7'h57};
            7'd18: pair = {7'h65, 7'h45};
            7'd19: pair = {7'h72, 7'h52};
            7'd20: pair = {7'h74, 7'h54};
            7'd21: pair = {7'h79, 7'h59};
            7'd22: pair = {7'h75, 7'h55};
            7'd23: pair = {7'h69, 7'h49};
            7'd24: pair = {7'h6f, 7'h4f};
            7'd25: pair = {7'h70, 7'h50};
            7'd26: pair = {7'h5b, 7'h7b};
            7'd27: pair = {7'h5d, 7'h7d};
            7'd28: pair = {7'h0a, 7'h0a};
            7'd30: pair = {7'h61, 7'h41};
            7'd31: pair = {7'h73, 7'h53};
            7'd32: pair = {7'h64, 7'h44};
            7'd33: pair = {7'h66, 7'h46};
            7'd34: pair = {7'h67, 7'h47};
            7'd35: pair = {7'h68, 7'h48};
            7'd36: pair = {7'h6a, 7'h4a};
            7'd37: pair = {7'h6b, 7'h4b};
            7'd38: pair = {7'h6c, 7'h4c};
            7'd39: pair = {7'h3b, 7'h3a};
            7'd40: pair = {7'h27, 7'h22};
            7'd41: pair = {7'h60, 7'h7e};
            7'd43: pair = {7'h5c, 7'h7c};
            7'd44: pair = {7'h7a, 7'h5a};
            7'd45: pair = {7'h78, 7'h58};
            7'd46: pair = {7'h63, 7'h43};
            7'd47: pair = {7'h76, 7'h56};
            7'd48: pair = {7'h62, 7'h42};
            7'd49: pair = {7'h6e, 7'h4e};
            7'd50: pair = {7'h6d, 7'h4d};
            7'd51: pair = {7'h2c, 7'h3c};
            7'd52: pair = {7'h2e, 7'h3e};
            7'd53: pair = {7'h2f, 7'h3f};
            7'd57: pair = {7'h20, 7'h20};
            default: pair = 14'h0;
        endcase
        case (idx)
            7'd29:   e.mod_mask = MOD_CTRL;
            7'd42:   e.mod_mask = MOD_SHIFT;
            7'd54:   e.mod_mask = MOD_SHIFT;
            7'd56:   e.mod_mask = MOD_ALT;
            7'd58:   e.mod_mask = MOD_META;
            default: e.mod_mask = 4'b0000;
        endcase
        e.is_mod = (e.mod_mask != 4'b0000);
        e.ch     = shift ? pair[6:0] : pair[13:7];
        return e;
    endfunction

endpackage

`default_nettype wire

>>> hdl/scta_if.sv
// Valid/ready channel interfaces for scan codes in and decoded events out.
`default_nettype none

interface scta_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface scta_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [6:0] char_code;
    logic [3:0] modifiers;

    modport source (output valid, output event_kind, output char_code, output modifiers,
                    input ready);
    modport sink   (input valid, input event_kind, input char_code, input modifiers,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/scta_decode.sv
// Combinational decode of one scan code against the current modifier bits.
`default_nettype none

module scta_decode
    import scta_pkg::*;
(
    input  wire logic [7:0] scan_code,
    input  wire logic [3:0] mods,
    output logic      [2:0] event_kind,
    output logic      [6:0] char_code,
    output logic      [3:0] mods_next
);

    key_entry_t entry;

    // Look up the key in the half chosen by shift
    assign entry = key_lookup(mods[0], scan_code[6:0]);

    // Classify make and break codes
    always_comb
    begin
        event_kind = EV_NONE;
        char_code  = 7'h0;
        mods_next  = mods;
        if (!scan_code[BREAK_BIT])
        begin
            if (entry.is_mod)
            begin
                mods_next = mods | entry.mod_mask;
            end
            else if (mods[MOD_CTRL_BIT])
            begin
                if (entry.ch == CH_C)
                begin
                    event_kind = EV_INTERRUPT;
                end
                else if (entry.ch == CH_D)
                begin
                    event_kind = EV_EOF;
                end
                else if (entry.ch == CH_Z)
                begin
                    event_kind = EV_STOP;
                end
            end
            else if (entry.ch != 7'h0)
            begin
                event_kind = EV_CHAR;
                char_code  = entry.ch;
            end
        end
        else if (entry.is_mod)
        begin
            mods_next = mods & ~entry.mod_mask;
        end
    end

endmodule

`default_nettype wire

>>> hdl/scancode_to_ascii_decoder.sv
// Top level: scan code input register, decode, and result register.
//
// Usage:
//   codes   : scan code bytes (bit 7 set = key release), valid/ready sink.
//   results : one event per scan code (event_kind, char_code, modifiers),
//             valid/ready source.
//   Each accepted scan code gives exactly one result, in order.
// Path: a code waits in the input register, is decoded as it moves into the
//   result register, and is presented from there; while the result register
//   is held by a stall, the code stays in the input register.
// Throughput: one code per cycle while results are taken; the modifier register
//   is updated as a code moves from the input register to the result register,
//   so consecutive codes see each other's modifier changes without a gap.
// Reset: rst_n clears both valid flags and the modifier bits (none held).
// Stall: while results.ready is low the result holds; the input register
//   still takes one more code if it is empty, then codes.ready drops until
//   the result is transferred.
`default_nettype none

module scancode_to_ascii_decoder
    import scta_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    scta_in_if.sink    codes,
    scta_out_if.source results
);

    logic       in_valid_reg;
    logic [7:0] in_code_reg;
    logic       out_valid_reg;
    logic [2:0] out_kind_reg;
    logic [6:0] out_char_reg;
    logic [3:0] mods_reg;
    logic [3:0] mods_next;
    logic [2:0] dec_kind;
    logic [6:0] dec_char;
    logic       out_free;
    logic       advance;

    // Advance when the result slot is empty or being transferred
    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = in_valid_reg && out_free;
    assign codes.ready = !in_valid_reg || advance;

    scta_decode u_decode (
        .scan_code  (in_code_reg),
        .mods       (mods_reg),
        .event_kind (dec_kind),
        .char_code  (dec_char),
        .mods_next  (mods_next)
    );

    // Hold control state: valid flags and modifier bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mods_reg      <= 4'b0000;
        end
        else
        begin
            if (codes.ready)
            begin
                in_valid_reg <= codes.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                mods_reg <= mods_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (codes.ready && codes.valid)
        begin
            in_code_reg <= codes.scan_code;
        end
        if (advance)
        begin
            out_kind_reg <= dec_kind;
            out_char_reg <= dec_char;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.event_kind = out_kind_reg;
    assign results.char_code  = out_char_reg;
    assign results.modifiers  = mods_reg;

endmodule

`default_nettype wire

>>> tb/sv/tb_scancode_to_ascii_decoder.sv
// Testbench for the scan code decoder: directed keys, random typing and back-pressure.
`default_nettype none

module tb_scancode_to_ascii_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import scta_pkg::*;

    localparam int unsigned KEY_LAST      = 58;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned STALL_CYCLES  = 300;
    localparam int unsigned RANDOM_CODES  = 265;
    localparam int unsigned PRESSURE_CODES = 40;

    // Scan codes used by the directed tests
    localparam logic [7:0] SC_RELEASE = 8'h80;
    localparam logic [7:0] SC_CTRL    = 8'h1d;
    localparam logic [7:0] SC_LSHIFT  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_ALT     = 8'h38;
    localparam logic [7:0] SC_META    = 8'h3a;
    localparam logic [7:0] SC_KEY_A   = 8'h1e;
    localparam logic [7:0] SC_KEY_C   = 8'h2e;
    localparam logic [7:0] SC_KEY_D   = 8'h20;
    localparam logic [7:0] SC_KEY_Z   = 8'h2c;
    localparam logic [7:0] SC_KEY_1   = 8'h02;
    localparam logic [7:0] SC_BLANK   = 8'h37;
    localparam logic [7:0] SC_SPACE   = 8'h39;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] ch;
        logic [3:0] mods;
    } decoded_t;

    // Character maps, plain and shifted; modifier keys and blanks hold zero
    logic [6:0] plain_map [0:KEY_LAST] = '{
        7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00
    };
    logic [6:0] shifted_map [0:KEY_LAST] = '{
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e,
        7'h26, 7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0a, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h00,
        7'h00, 7'h20, 7'h00
    };

    logic clk;
    logic rst_n;

    scta_in_if  codes_if ();
    scta_out_if results_if ();

    scancode_to_ascii_decoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .codes   (codes_if),
        .results (results_if)
    );

    logic [3:0]  tracked_mods;
    decoded_t    pending_events[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          stall_request;
    bit          recv_stalled;
    int unsigned error_count;
    int unsigned codes_sent;
    int unsigned results_seen;
    int unsigned chars_seen;
    int unsigned control_seen;
    int unsigned silent_seen;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Modifier mask of a key index, zero for ordinary keys
    function automatic logic [3:0] modifier_of(input logic [6:0] idx);
        case (idx)
            7'd29:        return MOD_CTRL;
            7'd42, 7'd54: return MOD_SHIFT;
            7'd56:        return MOD_ALT;
            7'd58:        return MOD_META;
            default:      return 4'b0000;
        endcase
    endfunction

    // Advance the tracked modifiers by one scan code and give the event it causes
    function automatic decoded_t decode_scan_code(input logic [7:0] code);
        decoded_t   res;
        logic [6:0] idx;
        logic [6:0] ch;
        logic [3:0] mask;
        idx  = code[6:0];
        mask = modifier_of(idx);
        ch   = 7'h00;
        if (idx <= KEY_LAST)
        begin
            ch = tracked_mods[0] ? shifted_map[idx] : plain_map[idx];
        end
        res      = '0;
        res.kind = EV_NONE;
        if (!code[BREAK_BIT])
        begin
            if (mask != 4'b0000)
            begin
                tracked_mods = tracked_mods | mask;
            end
            else if ((tracked_mods & MOD_CTRL) != 4'b0000)
            begin
                if (ch == CH_C)
                    res.kind = EV_INTERRUPT;
                else if (ch == CH_D)
                    res.kind = EV_EOF;
                else if (ch == CH_Z)
                    res.kind = EV_STOP;
            end
            else if (ch != 7'h00)
            begin
                res.kind = EV_CHAR;
                res.ch   = ch;
            end
        end
        else if (mask != 4'b0000)
        begin
            tracked_mods = tracked_mods & ~mask;
        end
        res.mods = tracked_mods;
        return res;
    endfunction

    // Offer one scan code, with random idle cycles first, and record its expected event
    task automatic send_code(input logic [7:0] code);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            codes_if.valid     <= 1'b0;
            codes_if.scan_code <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        codes_if.valid     <= 1'b1;
        codes_if.scan_code <= code;
        @(negedge clk);
        while (!codes_if.ready)
        begin
            @(negedge clk);
        end
        // The transfer happens at the coming edge
        pending_events.push_back(decode_scan_code(code));
        codes_sent++;
        @(posedge clk);
    endtask

    // Drive the receiver's ready at random, held low during a requested stall
    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            results_if.ready <= !recv_stalled && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Hold the receiver off for a long stretch when asked
    initial
    begin
        recv_stalled = 1'b0;
        forever
        begin
            wait (stall_request);
            @(negedge clk);
            stall_request = 1'b0;
            recv_stalled  = 1'b1;
            repeat (STALL_CYCLES) @(negedge clk);
            recv_stalled  = 1'b0;
        end
    end

    // Compare each result transfer with the oldest expected event
    initial
    begin
        decoded_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && results_if.valid && results_if.ready)
            begin
                results_seen++;
                if (pending_events.size() == 0)
                begin
                    $error("unexpected result: kind %0d char %0h mods %0h",
                           results_if.event_kind, results_if.char_code, results_if.modifiers);
                    error_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    case (want.kind)
                        EV_CHAR: chars_seen++;
                        EV_NONE: silent_seen++;
                        default: control_seen++;
                    endcase
                    if (results_if.event_kind !== want.kind)
                    begin
                        $error("event_kind mismatch: expected %0d, got %0d",
                               want.kind, results_if.event_kind);
                        error_count++;
                    end
                    if (results_if.char_code !== want.ch)
                    begin
                        $error("char_code mismatch: expected %0h, got %0h",
                               want.ch, results_if.char_code);
                        error_count++;
                    end
                    if (results_if.modifiers !== want.mods)
                    begin
                        $error("modifiers mismatch: expected %0h, got %0h",
                               want.mods, results_if.modifiers);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any transfer
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((codes_if.valid && codes_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Extremes, every event kind, modifier handling and release cases
    task automatic test_directed_keys();
        send_code(8'h00);                   // blank entry at the bottom of the map
        send_code(8'h7f);                   // highest make code, beyond the map
        send_code(SC_BLANK);                // blank entry inside the map
        send_code(SC_KEY_A);
        send_code(SC_SPACE);
        send_code(SC_LSHIFT);
        send_code(SC_KEY_1);                // shifted character
        send_code(SC_KEY_A | SC_RELEASE);   // release of an ordinary key
        send_code(SC_CTRL);                 // ctrl with shift held
        send_code(SC_KEY_C);                // upper-case C, no interrupt
        send_code(SC_LSHIFT | SC_RELEASE);
        send_code(SC_KEY_C);
        send_code(SC_KEY_D);
        send_code(SC_KEY_Z);
        send_code(SC_KEY_A);                // ctrl with other key gives nothing
        send_code(SC_ALT);                  // modifier key still sets its bit under ctrl
        send_code(SC_META);
        send_code(SC_RSHIFT);
        send_code(SC_RSHIFT | SC_RELEASE);
        send_code(SC_CTRL | SC_RELEASE);
        send_code(SC_ALT | SC_RELEASE);
        send_code(SC_META | SC_RELEASE);
        send_code(8'h80);
        send_code(8'hff);
    endtask

    // Typing sequences with random content, plus stray releases and noise bytes
    task automatic test_random_typing(input int unsigned count);
        logic [7:0]  mod_keys [0:4];
        logic [7:0]  code;
        int unsigned pick;
        mod_keys = '{SC_CTRL, SC_LSHIFT, SC_RSHIFT, SC_ALT, SC_META};
        for (int unsigned i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
                code = mod_keys[$urandom_range(0, 4)];
            else if (pick < 36)
                code = mod_keys[$urandom_range(0, 4)] | SC_RELEASE;
            else if (pick < 76)
                code = 8'($urandom_range(0, KEY_LAST));
            else if (pick < 88)
                code = 8'($urandom_range(0, 127)) | SC_RELEASE;
            else
                code = 8'($urandom_range(0, 255));
            send_code(code);
        end
    endtask

    // Stall the receiver while codes keep coming, so the input side backs up
    task automatic test_backpressure();
        stall_request = 1'b1;
        for (int unsigned i = 0; i < PRESSURE_CODES; i++)
        begin
            send_code(8'($urandom_range(0, KEY_LAST)));
        end
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        codes_if.valid      <= 1'b0;
        codes_if.scan_code  <= 8'h00;
        tracked_mods        = 4'b0000;
        send_idle_pct       = 27;
        recv_idle_pct       = 61;
        stall_request       = 1'b0;
        error_count         = 0;
        codes_sent          = 0;
        results_seen        = 0;
        chars_seen          = 0;
        control_seen        = 0;
        silent_seen         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keys();
        test_random_typing(RANDOM_CODES);

        send_idle_pct = 61;
        recv_idle_pct = 27;
        test_random_typing(RANDOM_CODES);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_typing(RANDOM_CODES);
        test_backpressure();

        // Drain outstanding results, then watch for stray ones
        codes_if.valid <= 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d scan codes and checked %0d results: %0d characters,",
                 codes_sent, results_seen, chars_seen);
        $display("  %0d ctrl events and %0d silent codes, with a %0d-cycle receiver stall.",
                 control_seen, silent_seen, STALL_CYCLES);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
